// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pse_pkg.sv =====
// ---------------------------------------------------------------------------
// pse_pkg
// shared types and codes of the pixel store with edge addressing
// ---------------------------------------------------------------------------
package pse_pkg;

	localparam int COORD_W = 16;
	localparam int DIM_W   = 7;
	localparam int COLOR_W = 32;
	localparam int MODE_W  = 2;
	localparam int OP_W    = 2;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [MODE_W-1:0] EDGE_NONE   = 2'd0;
	localparam logic [MODE_W-1:0] EDGE_WRAP   = 2'd1;
	localparam logic [MODE_W-1:0] EDGE_EXTEND = 2'd2;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_EDGE_MODE    = 2'd2;

	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 7'd64;
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 7'd64;
	localparam logic [MODE_W-1:0] RST_EDGE_MODE    = EDGE_NONE;

	typedef struct packed {
		logic [DIM_W-1:0]  image_width;
		logic [DIM_W-1:0]  image_height;
		logic [MODE_W-1:0] edge_mode;
	} cfg_t;

	typedef struct packed {
		logic             done;
		logic [DIM_W-1:0] value;
	} wrap_res_t;

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_WRAP   = 7'b0000100,
		ST_COORD  = 7'b0001000,
		ST_ACCESS = 7'b0010000,
		ST_DATA   = 7'b0100000,
		ST_CLEAR  = 7'b1000000
	} state_t;

endpackage

// ===== hw/rtl/pse_cfg.sv =====
// ---------------------------------------------------------------------------
// pse_cfg
// apb register file: image width, image height, edge mode
// ---------------------------------------------------------------------------
module pse_cfg import pse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.edge_mode    <= RST_EDGE_MODE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[DIM_W-1:0];
				REG_EDGE_MODE:    cfg_q.edge_mode    <= pwdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = {{(PDATA_W-DIM_W){1'b0}}, cfg_q.image_width};
			REG_IMAGE_HEIGHT: prdata = {{(PDATA_W-DIM_W){1'b0}}, cfg_q.image_height};
			REG_EDGE_MODE:    prdata = {{(PDATA_W-MODE_W){1'b0}}, cfg_q.edge_mode};
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/pse_wrap_unit.sv =====
// ---------------------------------------------------------------------------
// pse_wrap_unit
// bit-serial true modulo of a signed coordinate by an image dimension
// ---------------------------------------------------------------------------
module pse_wrap_unit import pse_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COORD_W-1:0] value,
	input  logic [DIM_W-1:0]          divisor,
	output wrap_res_t                 res
);

	localparam int CNT_W = $clog2(COORD_W);

	logic [COORD_W-1:0] mag_q;
	logic [DIM_W-1:0]   rem_q;
	logic [DIM_W-1:0]   div_q;
	logic               neg_q;
	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIM_W:0]     trial;
	logic [DIM_W-1:0]   rem_next;

	// one quotient bit per cycle
	assign trial    = {rem_q, mag_q[COORD_W-1]};
	assign rem_next = (trial >= {1'b0, div_q}) ? DIM_W'(trial - {1'b0, div_q})
	                                           : trial[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(COORD_W-1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= value[COORD_W-1] ? (~value + 1'b1) : value;
			neg_q <= value[COORD_W-1];
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[COORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	// negative remainder folds back into range
	assign res.done  = done_q;
	assign res.value = (neg_q && rem_q != '0) ? DIM_W'(div_q - rem_q) : rem_q;

endmodule

// ===== hw/rtl/pse_store.sv =====
// ---------------------------------------------------------------------------
// pse_store
// single-port pixel memory, registered read data
// ---------------------------------------------------------------------------
module pse_store import pse_pkg::*; #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic               clk,
	input  logic               we,
	input  logic               re,
	input  logic [ADDR_W-1:0]  addr,
	input  logic [COLOR_W-1:0] wdata,
	output logic [COLOR_W-1:0] rdata
);

	logic [COLOR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hw/rtl/pixel_store_edge_addressing.sv =====
// ---------------------------------------------------------------------------
// pixel_store_edge_addressing
// rgba pixel image in one memory with write, clear and edge-addressed read
// ---------------------------------------------------------------------------
// Items are taken one at a time. A write passes through the coord and access
// states before the next accept, a read through coord, access and data,
// waiting in data while an earlier result still holds the output register
// waiting on out_ready; a wrap read first passes the wrap state for the
// bit-serial modulo units (one coordinate bit per cycle, x and y in parallel).
// A clear writes one pixel per cycle through the single memory port, covering
// width * height pixels. After reset a clearing pass writes zero to all
// MAX_WIDTH * MAX_HEIGHT words, one per cycle, and in_ready stays low until it
// ends; configuration writes are taken throughout. Op code three is dropped.
// ---------------------------------------------------------------------------
module pixel_store_edge_addressing import pse_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [OP_W-1:0]           op,
	input  logic signed [COORD_W-1:0] x_coord,
	input  logic signed [COORD_W-1:0] y_coord,
	input  logic [COLOR_W-1:0]        color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COLOR_W-1:0]        read_color,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready
);

	`include "assert_macros.svh"

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W = 2 * DIM_W;

	cfg_t                      cfg;
	state_t                    state_q;
	logic [ADDR_W-1:0]         cnt_q;
	logic [ADDR_W-1:0]         last_q;
	logic                      out_valid_q;
	logic [COLOR_W-1:0]        read_color_q;
	logic [OP_W-1:0]           op_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic [COLOR_W-1:0]        color_q;
	logic [DIM_W-1:0]          wl_q;
	logic [DIM_W-1:0]          hl_q;
	logic [MODE_W-1:0]         model_q;
	logic [DIM_W-1:0]          cx_q;
	logic [DIM_W-1:0]          cy_q;
	logic                      in_range_q;

	logic [DIM_W-1:0]          w_eff;
	logic [DIM_W-1:0]          h_eff;
	logic                      in_fire;
	logic                      wrap_start;
	wrap_res_t                 wrap_x;
	wrap_res_t                 wrap_y;
	logic signed [COORD_W-1:0] wl_s;
	logic signed [COORD_W-1:0] hl_s;
	logic [DIM_W-1:0]          cx;
	logic [DIM_W-1:0]          cy;
	logic                      in_range;
	logic [PROD_W-1:0]         area;
	logic [PROD_W-1:0]         pix_idx;
	logic                      mem_we;
	logic                      mem_re;
	logic [ADDR_W-1:0]         mem_addr;
	logic [COLOR_W-1:0]        mem_wdata;
	logic [COLOR_W-1:0]        mem_rdata;
	logic                      sweep;
	logic                      sweep_end;
	logic                      out_load;

	pse_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective geometry: zero reads as one, large values saturate
	always_comb begin
		priority if (cfg.image_width == '0) begin
			w_eff = DIM_W'(1);
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = cfg.image_width;
		end
		priority if (cfg.image_height == '0) begin
			h_eff = DIM_W'(1);
		end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = cfg.image_height;
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid & in_ready;
	assign wrap_start = in_fire && (op == OP_READ) && (cfg.edge_mode == EDGE_WRAP);
	assign area       = PROD_W'(w_eff) * PROD_W'(h_eff);

	pse_wrap_unit u_wrap_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (wrap_start),
		.value   (x_coord),
		.divisor (w_eff),
		.res     (wrap_x)
	);

	pse_wrap_unit u_wrap_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (wrap_start),
		.value   (y_coord),
		.divisor (h_eff),
		.res     (wrap_y)
	);

	// coordinate resolve: range check, or clamp for extend reads
	assign wl_s = $signed({{(COORD_W-DIM_W){1'b0}}, wl_q});
	assign hl_s = $signed({{(COORD_W-DIM_W){1'b0}}, hl_q});

	always_comb begin
		cx       = x_q[DIM_W-1:0];
		cy       = y_q[DIM_W-1:0];
		in_range = (x_q >= 0) && (x_q < wl_s) && (y_q >= 0) && (y_q < hl_s);
		if (op_q == OP_READ && model_q == EDGE_EXTEND) begin
			in_range = 1'b1;
			priority if (x_q < 0) begin
				cx = '0;
			end else if (x_q >= wl_s) begin
				cx = DIM_W'(wl_q - 1'b1);
			end else begin
				cx = x_q[DIM_W-1:0];
			end
			priority if (y_q < 0) begin
				cy = '0;
			end else if (y_q >= hl_s) begin
				cy = DIM_W'(hl_q - 1'b1);
			end else begin
				cy = y_q[DIM_W-1:0];
			end
		end
	end

	assign pix_idx = PROD_W'(wl_q) * PROD_W'(cy_q) + PROD_W'(cx_q);

	// memory port
	assign sweep     = (state_q == ST_INIT) || (state_q == ST_CLEAR);
	assign sweep_end = (state_q == ST_INIT) ? (cnt_q == ADDR_W'(DEPTH - 1)) : (cnt_q == last_q);
	assign mem_we    = sweep || ((state_q == ST_ACCESS) && (op_q == OP_WRITE) && in_range_q);
	assign mem_re    = (state_q == ST_ACCESS) && (op_q == OP_READ) && in_range_q;
	assign mem_addr  = sweep ? cnt_q : ADDR_W'(pix_idx);
	assign mem_wdata = (state_q == ST_INIT) ? '0 : color_q;

	pse_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign out_load = (state_q == ST_DATA) && (!out_valid_q || out_ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT, ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (sweep_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_fire) begin
						priority if (op == OP_CLEAR) begin
							state_q <= ST_CLEAR;
						end else if (wrap_start) begin
							state_q <= ST_WRAP;
						end else if (op == OP_WRITE || op == OP_READ) begin
							state_q <= ST_COORD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_WRAP: begin
					if (wrap_x.done && wrap_y.done) begin
						state_q <= ST_COORD;
					end
				end
				ST_COORD: begin
					state_q <= ST_ACCESS;
				end
				ST_ACCESS: begin
					state_q <= (op_q == OP_READ) ? ST_DATA : ST_IDLE;
				end
				ST_DATA: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	// beat payload and item context
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= op;
			x_q     <= x_coord;
			y_q     <= y_coord;
			color_q <= color;
			wl_q    <= w_eff;
			hl_q    <= h_eff;
			model_q <= cfg.edge_mode;
			last_q  <= ADDR_W'(area - 1'b1);
		end else if (state_q == ST_WRAP && wrap_x.done && wrap_y.done) begin
			x_q <= $signed({{(COORD_W-DIM_W){1'b0}}, wrap_x.value});
			y_q <= $signed({{(COORD_W-DIM_W){1'b0}}, wrap_y.value});
		end
		if (state_q == ST_COORD) begin
			cx_q       <= cx;
			cy_q       <= cy;
			in_range_q <= in_range;
		end
		if (out_load) begin
			read_color_q <= in_range_q ? mem_rdata : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_color = read_color_q;

	`ASSERT_SAME(a_idle_no_store_write, in_ready, !mem_we, "memory written while idle")
	`ASSERT_NEXT(a_access_next, state_q == ST_ACCESS,
		(state_q == ST_DATA) || (state_q == ST_IDLE), "bad state after access")
	`ASSERT_SAME(a_wrap_in_range,
		(state_q == ST_COORD) && (op_q == OP_READ) && (model_q == EDGE_WRAP),
		(x_q >= 0) && (x_q < wl_s) && (y_q >= 0) && (y_q < hl_s), "wrapped coordinate out of range")

endmodule

// ===== bench/pixel_store_edge_addressing_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_store_edge_addressing_test
// self-checking bench for the pixel store with edge-addressed reads
// ---------------------------------------------------------------------------
// A driver pushes write, read, clear and unused-op beats from a pending
// queue. A monitor keeps its own copy of the pixel memory and the geometry
// registers, predicts every read, and checks the returned colors in order.
// Phases sweep image sizes (zero, saturated, tiny, full) and all edge modes,
// with registers written over apb and read back between phases.
// ---------------------------------------------------------------------------
module pixel_store_edge_addressing_test;
	import pse_pkg::*;

	localparam int MAX_W          = 64;
	localparam int MAX_H          = 64;
	localparam int N_PHASES       = 9;
	localparam int BEATS_PER_PHASE = 170;
	localparam int SETTLE_CYCLES  = 4200;

	localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
	localparam logic [MODE_W-1:0] EDGE_RSVD = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COLOR_W-1:0]        color;
	} pix_item_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      in_valid   = 1'b0;
	logic                      in_ready;
	logic [OP_W-1:0]           op         = '0;
	logic signed [COORD_W-1:0] x_coord    = '0;
	logic signed [COORD_W-1:0] y_coord    = '0;
	logic [COLOR_W-1:0]        color      = '0;
	logic                      out_valid;
	logic                      out_ready  = 1'b0;
	logic [COLOR_W-1:0]        read_color;
	logic                      psel       = 1'b0;
	logic                      penable    = 1'b0;
	logic                      pwrite     = 1'b0;
	logic [PADDR_W-1:0]        paddr      = '0;
	logic [PDATA_W-1:0]        pwdata     = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;

	pixel_store_edge_addressing #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.color     (color),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_color(read_color),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// model state
	logic [COLOR_W-1:0] pix_mem [MAX_W*MAX_H];
	logic [DIM_W-1:0]   width_reg  = RST_IMAGE_WIDTH;
	logic [DIM_W-1:0]   height_reg = RST_IMAGE_HEIGHT;
	logic [MODE_W-1:0]  mode_reg   = RST_EDGE_MODE;

	pix_item_t          pending_q [$];
	logic [COLOR_W-1:0] read_color_q [$];
	pix_item_t          drive_item;
	logic               in_beat_taken = 1'b0;
	int                 send_idle_pct = 25;
	int                 recv_idle_pct = 66;
	int                 fail_cnt      = 0;

	logic [DIM_W-1:0]  phase_w    [N_PHASES] = '{7'd8, 7'd1, 7'd0, 7'd64, 7'd100,
		7'd5, 7'd13, 7'd3, 7'd7};
	logic [DIM_W-1:0]  phase_h    [N_PHASES] = '{7'd4, 7'd1, 7'd127, 7'd64, 7'd3,
		7'd7, 7'd0, 7'd9, 7'd64};
	logic [MODE_W-1:0] phase_mode [N_PHASES] = '{EDGE_WRAP, EDGE_EXTEND, EDGE_NONE,
		EDGE_WRAP, EDGE_RSVD, EDGE_EXTEND, EDGE_WRAP, EDGE_NONE, EDGE_EXTEND};

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < MAX_W*MAX_H; i++)
			pix_mem[i] = '0;
	end

	function automatic int eff_dim(input logic [DIM_W-1:0] r, input int lim);
		if (r == 0)
			return 1;
		if (r > lim)
			return lim;
		return r;
	endfunction

	function automatic int wrap_mod(input int v, input int n);
		int r;
		r = v % n;
		if (r < 0)
			r += n;
		return r;
	endfunction

	function automatic int clamp_dim(input int v, input int n);
		if (v < 0)
			return 0;
		if (v >= n)
			return n - 1;
		return v;
	endfunction

	task automatic update_model(input pix_item_t it);
		int w, h, xi, yi;
		logic [COLOR_W-1:0] got;
		w  = eff_dim(width_reg, MAX_W);
		h  = eff_dim(height_reg, MAX_H);
		xi = $signed(it.x);
		yi = $signed(it.y);
		case (it.op)
			OP_WRITE: begin
				if (xi >= 0 && yi >= 0 && xi < w && yi < h)
					pix_mem[w*yi + xi] = it.color;
			end
			OP_CLEAR: begin
				for (int i = 0; i < w*h; i++)
					pix_mem[i] = it.color;
			end
			OP_READ: begin
				if (mode_reg == EDGE_WRAP) begin
					xi = wrap_mod(xi, w);
					yi = wrap_mod(yi, h);
				end else if (mode_reg == EDGE_EXTEND) begin
					xi = clamp_dim(xi, w);
					yi = clamp_dim(yi, h);
				end
				if (xi < 0 || yi < 0 || xi >= w || yi >= h)
					got = '0;
				else
					got = pix_mem[w*yi + xi];
				read_color_q.push_back(got);
			end
			default: ;
		endcase
	endtask

	function automatic pix_item_t mk_item(input logic [OP_W-1:0] o, input int xv,
		input int yv, input logic [COLOR_W-1:0] c);
		pix_item_t it;
		it.op    = o;
		it.x     = xv[COORD_W-1:0];
		it.y     = yv[COORD_W-1:0];
		it.color = c;
		return it;
	endfunction

	function automatic int pick_coord(input int n);
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: v = $urandom_range(n - 1);
			5, 6: v = int'($urandom_range(2*n + 3)) - (n + 2);
			7: v = $urandom;
			8: begin
				case ($urandom_range(3))
					0: v = -32768;
					1: v = 32767;
					2: v = -1;
					default: v = n;
				endcase
			end
			default: v = (int'($urandom_range(600)) - 300) * n + int'($urandom_range(2)) - 1;
		endcase
		return v;
	endfunction

	function automatic pix_item_t rand_item(input int w, input int h);
		int r;
		logic [OP_W-1:0] o;
		r = $urandom_range(99);
		if (r < 2)
			o = OP_CLEAR;
		else if (r < 6)
			o = OP_UNUSED;
		else if (r < 50)
			o = OP_WRITE;
		else
			o = OP_READ;
		return mk_item(o, pick_coord(w), pick_coord(h), $urandom);
	endfunction

	// register write followed by read-back over apb
	task automatic set_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val,
		input string name);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_IMAGE_WIDTH:  width_reg  = val[DIM_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = val[DIM_W-1:0];
			REG_EDGE_MODE:    mode_reg   = val[MODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== val) begin
			$error("%s mismatch: expected %h, actual %h", name, val, prdata);
			fail_cnt++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain_block();
		while (pending_q.size() != 0 || in_valid || read_color_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_beat_taken) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_item = pending_q.pop_front();
					in_valid <= 1'b1;
					op       <= drive_item.op;
					x_coord  <= drive_item.x;
					y_coord  <= drive_item.y;
					color    <= drive_item.color;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin : mon
		logic [COLOR_W-1:0] want;
		pix_item_t seen;
		in_beat_taken = in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (read_color_q.size() == 0) begin
				$error("read_color: unexpected beat, actual %h", read_color);
				fail_cnt++;
			end else begin
				want = read_color_q.pop_front();
				if (read_color !== want) begin
					$error("read_color mismatch: expected %h, actual %h", want, read_color);
					fail_cnt++;
				end
			end
		end
		if (arst_n && in_beat_taken) begin
			seen = {op, x_coord, y_coord, color};
			update_model(seen);
		end
	end

	initial begin : stim
		int w, h;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset geometry 64 x 64, edge none
		pending_q.push_back(mk_item(OP_WRITE, 0, 0, 32'hFFFF_FFFF));
		pending_q.push_back(mk_item(OP_WRITE, 63, 63, 32'hA5A5_A5A5));
		pending_q.push_back(mk_item(OP_WRITE, 63, 0, 32'h1234_5678));
		pending_q.push_back(mk_item(OP_WRITE, 0, 63, 32'h8000_0001));
		pending_q.push_back(mk_item(OP_WRITE, -1, 0, 32'hDEAD_BEEF));
		pending_q.push_back(mk_item(OP_WRITE, 64, 5, 32'hDEAD_BEEF));
		pending_q.push_back(mk_item(OP_WRITE, 5, 64, 32'hDEAD_BEEF));
		pending_q.push_back(mk_item(OP_WRITE, -32768, -32768, 32'hDEAD_BEEF));
		pending_q.push_back(mk_item(OP_WRITE, 32767, 32767, 32'hDEAD_BEEF));
		pending_q.push_back(mk_item(OP_READ, 0, 0, 32'h0));
		pending_q.push_back(mk_item(OP_READ, 63, 63, 32'hFFFF_FFFF));
		pending_q.push_back(mk_item(OP_READ, 63, 0, 32'h0));
		pending_q.push_back(mk_item(OP_READ, 0, 63, 32'h0));
		pending_q.push_back(mk_item(OP_READ, -1, 0, 32'h0));
		pending_q.push_back(mk_item(OP_READ, 64, 63, 32'h0));
		pending_q.push_back(mk_item(OP_READ, 32767, -32768, 32'h0));
		pending_q.push_back(mk_item(OP_UNUSED, 1, 1, 32'hCAFE_F00D));
		pending_q.push_back(mk_item(OP_READ, 1, 1, 32'h0));
		pending_q.push_back(mk_item(OP_CLEAR, -5, 7, 32'h0F1E_2D3C));
		pending_q.push_back(mk_item(OP_READ, 10, 20, 32'h0));
		pending_q.push_back(mk_item(OP_READ, 63, 63, 32'h0));
		pending_q.push_back(mk_item(OP_WRITE, 10, 20, 32'h0000_0000));
		pending_q.push_back(mk_item(OP_READ, 10, 20, 32'h0));
		drain_block();

		for (int p = 0; p < N_PHASES; p++) begin
			send_idle_pct = (p < 3) ? 25 : (p < 6) ? 66 : 0;
			recv_idle_pct = (p < 3) ? 66 : (p < 6) ? 25 : 0;
			set_reg(REG_IMAGE_WIDTH, PDATA_W'(phase_w[p]), "image_width");
			set_reg(REG_IMAGE_HEIGHT, PDATA_W'(phase_h[p]), "image_height");
			set_reg(REG_EDGE_MODE, PDATA_W'(phase_mode[p]), "edge_mode");
			w = eff_dim(phase_w[p], MAX_W);
			h = eff_dim(phase_h[p], MAX_H);
			for (int k = 0; k < BEATS_PER_PHASE; k++)
				pending_q.push_back(rand_item(w, h));
			drain_block();
		end

		if (fail_cnt == 0 && read_color_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pse_pkg.sv
hw/rtl/pse_cfg.sv
hw/rtl/pse_wrap_unit.sv
hw/rtl/pse_store.sv
hw/rtl/pixel_store_edge_addressing.sv
bench/pixel_store_edge_addressing_test.sv
